// ----- rtl/lr_pkg.sv -----
// Shared types and constants for the line rasterizer.
package lr_pkg;

	localparam int DEF_COLUMNS = 1024;
	localparam int COORD_W     = 10;
	localparam int COLOR_W     = 24;
	localparam int OFFSET_W    = 20;
	localparam int ERR_W       = 12;
	localparam int QUEUE_DEPTH = 4;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
		logic [COLOR_W-1:0] paint;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0]  pixel_x;
		logic [COORD_W-1:0]  pixel_y;
		logic [OFFSET_W-1:0] pixel_offset;
		logic [COLOR_W-1:0]  pixel_color;
		logic                last;
	} pixel_t;

	// classified request as held in the queue
	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
		logic [COLOR_W-1:0] color;
		logic               col_down;
		logic               row_down;
		logic               rows_major;
		logic [COORD_W-1:0] major;
		logic [COORD_W-1:0] minor;
	} cmd_t;

endpackage

// ----- rtl/lr_front.sv -----
// Front end: accepts requests and works out octant and deltas for each request.
module lr_front (
	input  lr_pkg::item_t item,
	input  logic          item_valid,
	input  logic          full,
	output logic          item_stall,
	output logic          push,
	output lr_pkg::cmd_t  cmd
);
	import lr_pkg::*;

	logic               col_down;
	logic               row_down;
	logic               rows_major;
	logic [COORD_W-1:0] adx;
	logic [COORD_W-1:0] ady;

	always_comb begin
		col_down   = item.x_end < item.x_start;
		row_down   = item.y_end < item.y_start;
		adx        = col_down ? item.x_start - item.x_end : item.x_end - item.x_start;
		ady        = row_down ? item.y_start - item.y_end : item.y_end - item.y_start;
		// columns win a tie
		rows_major = ady > adx;

		cmd.kind       = item.kind;
		cmd.x_start    = item.x_start;
		cmd.y_start    = item.y_start;
		cmd.x_end      = item.x_end;
		cmd.y_end      = item.y_end;
		cmd.color      = item.paint;
		cmd.col_down   = col_down;
		cmd.row_down   = row_down;
		cmd.rows_major = rows_major;
		cmd.major      = rows_major ? ady : adx;
		cmd.minor      = rows_major ? adx : ady;
	end

	assign item_stall = full;
	assign push       = item_valid && !full;

endmodule

// ----- rtl/lr_queue.sv -----
// Short request queue between front and back end.
module lr_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  lr_pkg::cmd_t wdata,
	input  logic         pop,
	output lr_pkg::cmd_t rdata,
	output logic         empty,
	output logic         full
);
	import lr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign empty = count_q == '0;
	assign full  = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/lr_back.sv -----
// Back end: holds the active line, steps it and registers each pixel.
module lr_back #(
	parameter int COLUMNS = lr_pkg::DEF_COLUMNS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lr_pkg::cmd_t  head,
	input  logic          head_valid,
	output logic          pop,
	output lr_pkg::pixel_t pixel,
	output logic          pixel_valid,
	input  logic          pixel_stall
);
	import lr_pkg::*;

	localparam logic [12:0] COL_MULT = 13'(COLUMNS);

	logic [COORD_W-1:0]     cur_col_q, cur_row_q, end_col_q, end_row_q;
	logic [COORD_W-1:0]     major_q, minor_q;
	logic signed [ERR_W-1:0] err_q;
	logic                   col_down_q, row_down_q, rows_major_q;
	logic                   busy_q;
	logic [COLOR_W-1:0]     color_q;
	pixel_t                 pixel_q;
	logic                   pixel_valid_q;

	logic                   can_load;
	logic                   is_last;
	logic                   err_pos;
	logic                   emit;
	logic [COORD_W-1:0]     col_next, row_next;
	logic signed [ERR_W-1:0] err_next, err_start;
	logic [22:0]            row_prod;

	always_comb begin
		can_load = !pixel_valid_q || !pixel_stall;
		pop      = head_valid && can_load;
		emit     = pop && (head.kind == KIND_STEP) && busy_q;
		is_last  = rows_major_q ? (cur_row_q == end_row_q) : (cur_col_q == end_col_q);
		err_pos  = err_q > 0;

		col_next = cur_col_q;
		row_next = cur_row_q;
		err_next = err_q + $signed({2'b00, minor_q});
		if (err_pos) begin
			err_next = err_next - $signed({2'b00, major_q});
			if (rows_major_q) begin
				col_next = col_down_q ? cur_col_q - 1'b1 : cur_col_q + 1'b1;
			end else begin
				row_next = row_down_q ? cur_row_q - 1'b1 : cur_row_q + 1'b1;
			end
		end
		if (rows_major_q) begin
			row_next = row_down_q ? cur_row_q - 1'b1 : cur_row_q + 1'b1;
		end else begin
			col_next = col_down_q ? cur_col_q - 1'b1 : cur_col_q + 1'b1;
		end

		err_start = $signed({2'b00, head.minor}) - $signed({3'b000, head.major[COORD_W-1:1]});
		row_prod  = cur_row_q * COL_MULT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			pixel_valid_q <= 1'b0;
		end else begin
			if (pixel_valid_q && !pixel_stall) begin
				pixel_valid_q <= 1'b0;
			end
			if (emit) begin
				pixel_valid_q <= 1'b1;
			end
			if (pop && head.kind == KIND_START) begin
				busy_q <= 1'b1;
			end else if (emit && is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == KIND_START) begin
			cur_col_q    <= head.x_start;
			cur_row_q    <= head.y_start;
			end_col_q    <= head.x_end;
			end_row_q    <= head.y_end;
			major_q      <= head.major;
			minor_q      <= head.minor;
			col_down_q   <= head.col_down;
			row_down_q   <= head.row_down;
			rows_major_q <= head.rows_major;
			color_q      <= head.color;
			err_q        <= err_start;
		end else if (emit && !is_last) begin
			cur_col_q <= col_next;
			cur_row_q <= row_next;
			err_q     <= err_next;
		end
		if (emit) begin
			pixel_q.pixel_x      <= cur_col_q;
			pixel_q.pixel_y      <= cur_row_q;
			pixel_q.pixel_offset <= row_prod[OFFSET_W-1:0] + OFFSET_W'(cur_col_q);
			pixel_q.pixel_color  <= color_q;
			pixel_q.last         <= is_last;
		end
	end

	assign pixel       = pixel_q;
	assign pixel_valid = pixel_valid_q;

endmodule

// ----- rtl/line_rasterizer_top.sv -----
// Top level of the line rasterizer.
// Bresenham line drawer, one pixel per clock while the output is not stalled. A start
// request (kind = 0) loads both endpoints and the color and produces no pixel; each step
// request (kind = 1) produces the next pixel of the active line with its frame-buffer
// offset (row * COLUMNS + column, low 20 bits), and last marks the second endpoint. A
// line of major delta N gives N + 1 pixels; steps with no active line are dropped, and a
// start drops any line in progress. Every request, start or step, is popped by the
// stepping unit in turn, so the block sustains one request per clock while the output is
// not stalled; with the queue empty and the output free, the classified request is
// written into a four-entry queue when it is accepted, and the stepping unit then pops it
// and loads its output register, from which the pixel of a step request is presented.
// A stalled output holds the queue, and input stall rises once it is full.
module line_rasterizer_top #(
	parameter int COLUMNS = lr_pkg::DEF_COLUMNS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lr_pkg::item_t  item,
	input  logic           item_valid,
	output logic           item_stall,
	output lr_pkg::pixel_t pixel,
	output logic           pixel_valid,
	input  logic           pixel_stall
);
	import lr_pkg::*;

	cmd_t q_wdata;
	cmd_t q_rdata;
	logic q_push;
	logic q_pop;
	logic q_empty;
	logic q_full;

	lr_front u_front (
		.item       (item),
		.item_valid (item_valid),
		.full       (q_full),
		.item_stall (item_stall),
		.push       (q_push),
		.cmd        (q_wdata)
	);

	lr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	lr_back #(
		.COLUMNS (COLUMNS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_rdata),
		.head_valid  (!q_empty),
		.pop         (q_pop),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> pixel.pixel_offset ==
			OFFSET_W'(pixel.pixel_y * COLUMNS + pixel.pixel_x))
		else $error("pixel offset does not match coordinates");

	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_stall) |-> !q_pop)
		else $error("request taken while pixel output is stalled");

endmodule
